// File: hw/rtl/rjpb_pkg.sv
// Shared types and constants for the radial jump pair blanker.
// Holds payload structs, command and write-port structs, and register codes.
`default_nettype none

package rjpb_pkg;

    localparam int VEL_W = 16;
    localparam int CNT_W = 7;    // gate count and buffer fill, covers a 64 gate span
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPAN_LIM_W = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_LIMIT     = 2'd0,
        CFG_SPAN_LIMIT     = 2'd1,
        CFG_DATA_THRESHOLD = 2'd2,
        CFG_MISSING_CODE   = 2'd3
    } t_cfg_idx;

    localparam logic [15:0]           RST_JUMP_LIMIT     = 16'd0;
    localparam logic [SPAN_LIM_W-1:0] RST_SPAN_LIMIT     = 6'd30;
    localparam logic signed [15:0]    RST_DATA_THRESHOLD = 16'sd32767;
    localparam logic signed [15:0]    RST_MISSING_CODE   = 16'sd32767;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    radial_end;
    } t_in;

    typedef struct packed {
        logic signed [VEL_W-1:0] gate_value;
        logic                    was_blanked;
        logic                    radial_done;
        logic                    run_last;
    } t_out;

    typedef struct packed {
        logic [15:0]           jump_limit;
        logic [SPAN_LIM_W-1:0] span_limit;
        logic signed [15:0]    data_threshold;
        logic signed [15:0]    missing_code;
    } t_cfg;

    // One unit of back-end work: n buffered gates, then optionally the gate itself.
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic                    bank;
        logic                    blank;
        logic                    direct;
        logic signed [VEL_W-1:0] value;
        logic                    done;
    } t_cmd;

    typedef struct packed {
        logic                    en;
        logic                    bank;
        logic [CNT_W-1:0]        idx;
        logic signed [VEL_W-1:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

// File: hw/rtl/radial_jump_pair_blanker.sv
// Radial jump pair blanker: front end, command queue and back end, plus config.
// Depends on rjpb_pkg, rjpb_front, rjpb_cmd_fifo and rjpb_back.
// A gate not held in a span goes through the queue, stage 1 and the output register.
// Throughput: one result per cycle from the single buffer read port unless output stalls;
//   input stalls while the queue is full or both banks wait.
// Reset: control state and config return to reset values; the span buffer is not cleared.
`default_nettype none

module radial_jump_pair_blanker #(
    parameter int SPAN_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // gate input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire rjpb_pkg::t_in                   i_in_data,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output rjpb_pkg::t_out                       o_out_data,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rjpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rjpb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rjpb_pkg::*;

    t_cfg    r_cfg;
    t_cmd    push_cmd, head_cmd;
    t_mem_wr mem_wr;
    logic    push, fifo_full, head_valid, pop, flush_done;

    // Config writes always taken; user must write only while idle, unenforced by block.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_limit     <= RST_JUMP_LIMIT;
            r_cfg.span_limit     <= RST_SPAN_LIMIT;
            r_cfg.data_threshold <= RST_DATA_THRESHOLD;
            r_cfg.missing_code   <= RST_MISSING_CODE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_JUMP_LIMIT:     r_cfg.jump_limit     <= i_cfg_data;
                CFG_SPAN_LIMIT:     r_cfg.span_limit     <= i_cfg_data[SPAN_LIM_W-1:0];
                CFG_DATA_THRESHOLD: r_cfg.data_threshold <= i_cfg_data;
                CFG_MISSING_CODE:   r_cfg.missing_code   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: classify each gate, buffer span gates, queue the emit work.
    rjpb_front #(
        .SPAN_DEPTH (SPAN_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_fifo_full  (fifo_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr         (mem_wr),
        .i_flush_done (flush_done)
    );

    // Short queue so that front and back stall independently.
    rjpb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    // Back end: drain buffered spans (blanked or not) and pass direct gates.
    rjpb_back #(
        .SPAN_DEPTH (SPAN_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_wr         (mem_wr),
        .i_cmd_valid  (head_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_flush_done (flush_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rjpb_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on rjpb_pkg for the command type.
`default_nettype none

module rjpb_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rjpb_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output rjpb_pkg::t_cmd     o_cmd
);
    import rjpb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            if (do_push && !do_pop)      r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wr_ptr] <= i_cmd;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rjpb_front.sv
// Front end: accepts gates, detects jumps, tracks the span and queues work.
// Depends on rjpb_pkg; writes the span buffer through a write-port struct.
`default_nettype none

module rjpb_front #(
    parameter int SPAN_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rjpb_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire rjpb_pkg::t_in i_in_data,
    input  wire logic          i_fifo_full,
    output logic               o_push,
    output rjpb_pkg::t_cmd     o_cmd,
    output rjpb_pkg::t_mem_wr  o_wr,
    input  wire logic          i_flush_done
);
    import rjpb_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SPAN_DEPTH);

    logic signed [VEL_W-1:0] r_prev, n_prev;
    logic                    r_have, n_have;
    logic                    r_open, n_open;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic                    r_bank;
    logic [1:0]              r_pending;

    logic                    accept;
    logic signed [VEL_W:0]   diff;
    logic [VEL_W:0]          mag;
    logic                    jump;
    logic                    flush_a, flush_b, direct, wr_en;
    logic [CNT_W-1:0]        flush_n, wr_idx;
    logic [CNT_W-1:0]        cnt_lim;
    logic                    flush_any;

    // Hold input while the queue is full or both buffer banks await reading.
    assign o_in_stall = i_fifo_full || r_pending[1];
    assign accept     = i_in_valid && !o_in_stall;

    assign diff = {i_in_data.velocity[VEL_W-1], i_in_data.velocity}
                - {r_prev[VEL_W-1], r_prev};
    assign mag  = diff[VEL_W] ? (VEL_W+1)'(-diff) : (VEL_W+1)'(diff);
    assign jump = r_have
               && (i_in_data.velocity < i_cfg.data_threshold)
               && (r_prev < i_cfg.data_threshold)
               && (mag > (VEL_W+1)'(i_cfg.jump_limit));
    assign cnt_lim = {1'b0, i_cfg.span_limit} + CNT_W'(1);

    always_comb begin
        n_cnt   = r_cnt;
        n_open  = r_open;
        n_fill  = r_fill;
        n_prev  = i_in_data.velocity;
        n_have  = 1'b1;
        flush_a = 1'b0;
        flush_b = 1'b0;
        flush_n = '0;
        direct  = 1'b0;
        wr_en   = 1'b0;
        wr_idx  = '0;

        if (r_have) begin
            if (r_cnt != CNT_MAX) n_cnt = r_cnt + CNT_W'(1);
            if (jump) begin
                if (!r_open) begin
                    n_open = 1'b1;
                    n_fill = '0;
                end else begin
                    flush_a = 1'b1;
                    flush_n = r_fill;
                    n_open  = 1'b0;
                    n_fill  = '0;
                end
                n_cnt = '0;
            end
        end

        if (n_open) begin
            if (n_fill < DEPTH_CNT) begin
                wr_en  = 1'b1;
                wr_idx = n_fill;
                n_fill = n_fill + CNT_W'(1);
            end
        end else begin
            direct = 1'b1;
        end

        if (n_cnt > cnt_lim) begin
            if (n_open) begin
                flush_b = 1'b1;
                flush_n = n_fill;
                n_open  = 1'b0;
                n_fill  = '0;
            end
            n_cnt = '0;
        end else if (n_open && n_fill >= DEPTH_CNT) begin
            flush_b = 1'b1;
            flush_n = n_fill;
            n_open  = 1'b0;
            n_fill  = '0;
        end

        if (i_in_data.radial_end) begin
            if (n_open) begin
                flush_b = 1'b1;
                flush_n = n_fill;
                n_open  = 1'b0;
                n_fill  = '0;
            end
            n_have = 1'b0;
            n_prev = '0;
            n_cnt  = '0;
        end
    end

    assign flush_any = flush_a || flush_b;
    assign o_push    = accept && (flush_any || direct);

    always_comb begin
        o_cmd.n      = flush_n;
        o_cmd.bank   = r_bank;
        o_cmd.blank  = flush_a;
        o_cmd.direct = direct;
        o_cmd.value  = i_in_data.velocity;
        o_cmd.done   = i_in_data.radial_end;
        o_wr.en      = accept && wr_en;
        o_wr.bank    = r_bank;
        o_wr.idx     = wr_idx;
        o_wr.data    = i_in_data.velocity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_have    <= 1'b0;
            r_open    <= 1'b0;
            r_cnt     <= '0;
            r_fill    <= '0;
            r_bank    <= 1'b0;
            r_pending <= 2'd0;
        end else begin
            if (accept) begin
                r_prev <= n_prev;
                r_have <= n_have;
                r_open <= n_open;
                r_cnt  <= n_cnt;
                r_fill <= n_fill;
                if (flush_any) r_bank <= !r_bank;
            end
            if ((accept && flush_any) && !i_flush_done)      r_pending <= r_pending + 2'd1;
            else if (!(accept && flush_any) && i_flush_done) r_pending <= r_pending - 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rjpb_back.sv
// Back end: replays queued commands, reading the span buffer and driving results.
// Depends on rjpb_pkg; owns the two-bank span buffer memory.
`default_nettype none

module rjpb_back #(
    parameter int SPAN_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rjpb_pkg::t_cfg i_cfg,
    input  wire rjpb_pkg::t_mem_wr i_wr,
    input  wire logic          i_cmd_valid,
    input  wire rjpb_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_flush_done,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output rjpb_pkg::t_out     o_out_data
);
    import rjpb_pkg::*;

    localparam int AW = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
    localparam int MEM_DEPTH = 2 ** (AW + 1);

    logic signed [VEL_W-1:0] r_mem [MEM_DEPTH];
    logic signed [VEL_W-1:0] r_rdata;

    logic [CNT_W-1:0]        r_idx;
    logic                    r_s1_vld, r_s1_direct, r_s1_blank, r_s1_last, r_s1_done;
    logic signed [VEL_W-1:0] r_s1_value;
    logic                    r_out_vld;
    t_out                    r_out;

    logic out_adv, s1_free, issue, is_read, tok_last;
    logic blank_hit;

    assign out_adv  = !r_out_vld || !i_out_stall;
    assign s1_free  = !r_s1_vld || out_adv;
    assign issue    = i_cmd_valid && s1_free;
    assign is_read  = (r_idx < i_cmd.n);
    assign tok_last = is_read ? ((r_idx == i_cmd.n - CNT_W'(1)) && !i_cmd.direct) : 1'b1;

    assign o_pop        = issue && tok_last;
    assign o_flush_done = issue && is_read && (r_idx == i_cmd.n - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[{i_wr.bank, i_wr.idx[AW-1:0]}] <= i_wr.data;
        if (issue && is_read) r_rdata <= r_mem[{i_cmd.bank, r_idx[AW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= tok_last ? '0 : r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_direct <= !is_read;
            r_s1_blank  <= i_cmd.blank;
            r_s1_last   <= tok_last;
            r_s1_done   <= tok_last && i_cmd.done;
            r_s1_value  <= i_cmd.value;
        end
    end

    assign blank_hit = !r_s1_direct && r_s1_blank && (r_rdata < i_cfg.data_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out.gate_value  <= r_s1_direct ? r_s1_value
                               : (blank_hit ? i_cfg.missing_code : r_rdata);
            r_out.was_blanked <= blank_hit;
            r_out.radial_done <= r_s1_done;
            r_out.run_last    <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
